@@ design/lsbp_pkg.sv @@
package lsbp_pkg;

    localparam int LEDS_DEFAULT  = 256;
    localparam int SLOTS_PER_LED = 24;
    localparam int SLOT_W        = 5;
    localparam int PIXEL_W       = 24;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_LED - 1);

    // Decoded view of one incoming transaction.
    typedef struct packed {
        logic               is_read;
        logic               skip;
        logic               out_of_range;
        logic [PIXEL_W-1:0] bits;
    } plan_t;

endpackage

@@ design/lsbp_decode.sv @@
module lsbp_decode #(
    parameter int LEDS  = lsbp_pkg::LEDS_DEFAULT,
    parameter int LED_W = (LEDS > 1) ? $clog2(LEDS) : 1
) (
    input  logic                          command,
    input  logic [2:0]                    strip,
    input  logic [7:0]                    first_led,
    input  logic [7:0]                    offset,
    input  logic                          inverted,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    read_led,
    input  logic [23:0]                   color_orders,
    output lsbp_pkg::plan_t               plan,
    output logic [LED_W-1:0]              led
);

    localparam logic CMD_READ = 1'b1;

    localparam logic [2:0] ORDER_RGB = 3'd0;
    localparam logic [2:0] ORDER_GBR = 3'd1;
    localparam logic [2:0] ORDER_BRG = 3'd2;
    localparam logic [2:0] ORDER_BGR = 3'd3;
    localparam logic [2:0] ORDER_GRB = 3'd4;
    localparam logic [2:0] ORDER_RBG = 3'd5;

    logic [8:0]  target;
    logic        below_zero;
    logic        target_ok;
    logic        read_ok;
    logic [2:0]  order;
    logic        order_ok;
    logic [23:0] pixel;

    assign below_zero = inverted && (offset > first_led);
    assign target     = inverted ? ({1'b0, first_led} - {1'b0, offset})
                                 : ({1'b0, first_led} + {1'b0, offset});
    assign target_ok  = !below_zero && (32'(target) < LEDS);
    assign read_ok    = 32'(read_led) < LEDS;
    assign order      = color_orders[3*strip +: 3];

    always_comb
    begin
        order_ok = 1'b1;
        pixel    = '0;
        unique case (order)
            ORDER_RGB: pixel = {red, green, blue};
            ORDER_GBR: pixel = {green, blue, red};
            ORDER_BRG: pixel = {blue, red, green};
            ORDER_BGR: pixel = {blue, green, red};
            ORDER_GRB: pixel = {green, red, blue};
            ORDER_RBG: pixel = {red, blue, green};
            default:   order_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        plan.is_read      = (command == CMD_READ);
        plan.bits         = pixel;
        plan.out_of_range = !read_ok;
        if (plan.is_read)
        begin
            plan.skip = 1'b0;
            led       = read_ok ? LED_W'(read_led) : '0;
        end
        else
        begin
            plan.skip = !(target_ok && order_ok);
            led       = target_ok ? LED_W'(target) : '0;
        end
    end

endmodule

@@ design/led_strip_bitplane_packer_core.sv @@
// Bit-transposed frame buffer for eight parallel LED strips, held in one
// single-port-write, registered-read memory of LEDS*24 bytes. A write
// transaction updates one strip's bit in the 24 bytes of one LED by
// read-modify-write, one byte per cycle, so it passes through the accepting
// cycle, the reads of the 24 bytes and the final write-back; a dropped write
// is taken without leaving the idle state. A read transaction takes the
// accepting cycle and then streams the 24 bytes of one LED, one per cycle
// when the downstream side is ready, and the next transaction is taken from
// the cycle after the last byte has been accepted. After reset the buffer
// is zeroed by a sweep over all LEDS*24 bytes, during which no transaction
// is taken; configuration writes are accepted at any time.
module led_strip_bitplane_packer_core #(
    parameter int LEDS = lsbp_pkg::LEDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // strip[2:0], first_led[10:3], offset[18:11], inverted[19], red[27:20],
    // green[35:28], blue[43:36], read_led[51:44], zero padding[55:52]
    input  logic [55:0] s_axis_tdata,
    // command[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lane_byte[7:0], slot[12:8], zero padding[15:13]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int LED_W  = (LEDS > 1) ? $clog2(LEDS) : 1;
    localparam int DEPTH  = LEDS * lsbp_pkg::SLOTS_PER_LED;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ADDR_W-1:0]               addr_reg, addr_next;
    logic [lsbp_pkg::SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [lsbp_pkg::PIXEL_W-1:0]    bits_reg, bits_next;
    logic [2:0]                      strip_reg, strip_next;
    logic                            oor_reg, oor_next;
    logic                            wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]               wb_addr_reg, wb_addr_next;
    logic                            wb_bit_reg, wb_bit_next;
    logic                            m_valid_reg, m_valid_next;
    logic [lsbp_pkg::SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic                            m_last_reg, m_last_next;
    logic [23:0]                     orders_reg;

    logic [7:0]                      mem [DEPTH];
    logic [7:0]                      mem_q;
    logic                            mem_re;
    logic [ADDR_W-1:0]               mem_raddr;
    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;
    logic [7:0]                      mem_wdata;

    lsbp_pkg::plan_t                 plan;
    logic [LED_W-1:0]                led;
    logic [ADDR_W-1:0]               base_addr;
    logic                            accept;
    logic                            issue_read;

    lsbp_decode #(
        .LEDS  (LEDS),
        .LED_W (LED_W)
    ) u_decode (
        .command      (s_axis_tuser[0]),
        .strip        (s_axis_tdata[2:0]),
        .first_led    (s_axis_tdata[10:3]),
        .offset       (s_axis_tdata[18:11]),
        .inverted     (s_axis_tdata[19]),
        .red          (s_axis_tdata[27:20]),
        .green        (s_axis_tdata[35:28]),
        .blue         (s_axis_tdata[43:36]),
        .read_led     (s_axis_tdata[51:44]),
        .color_orders (orders_reg),
        .plan         (plan),
        .led          (led)
    );

    assign base_addr = (ADDR_W'(led) << 4) + (ADDR_W'(led) << 3);

    assign s_axis_tready = (state_reg == ST_IDLE) && !wb_valid_reg && !m_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign issue_read    = (state_reg == ST_READ) && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        bits_next     = bits_reg;
        strip_next    = strip_reg;
        oor_next      = oor_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        wb_bit_next   = wb_bit_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_slot_next   = m_slot_reg;
        m_last_next   = m_last_reg;
        mem_re        = 1'b0;
        mem_raddr     = addr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = base_addr;
                    cnt_next   = '0;
                    bits_next  = plan.bits;
                    strip_next = s_axis_tdata[2:0];
                    if (plan.is_read)
                    begin
                        oor_next   = plan.out_of_range;
                        state_next = ST_READ;
                    end
                    else if (!plan.skip)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_re        = 1'b1;
                wb_valid_next = 1'b1;
                wb_addr_next  = addr_reg;
                wb_bit_next   = bits_reg[lsbp_pkg::PIXEL_W-1];
                bits_next     = {bits_reg[lsbp_pkg::PIXEL_W-2:0], 1'b0};
                addr_next     = addr_reg + 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == lsbp_pkg::LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (issue_read)
                begin
                    mem_re       = 1'b1;
                    m_valid_next = 1'b1;
                    m_slot_next  = cnt_reg;
                    m_last_next  = (cnt_reg == lsbp_pkg::LAST_SLOT);
                    addr_next    = addr_reg + 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == lsbp_pkg::LAST_SLOT)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wb_addr_reg;
        mem_wdata = mem_q;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = '0;
        end
        else if (wb_valid_reg)
        begin
            mem_we               = 1'b1;
            mem_wdata[strip_reg] = wb_bit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            cnt_reg      <= '0;
            oor_reg      <= 1'b0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            orders_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            cnt_reg      <= cnt_next;
            oor_reg      <= oor_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we)
            begin
                orders_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg    <= bits_next;
        strip_reg   <= strip_next;
        wb_addr_reg <= wb_addr_next;
        wb_bit_reg  <= wb_bit_next;
        m_slot_reg  <= m_slot_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {3'b000, m_slot_reg, oor_reg ? 8'h00 : mem_q};

    // A write-back only ever follows a read issued by the write sequence.
    a_wb_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> $past(state_reg == ST_WRITE))
        else $error("write-back without a preceding modify read");

    // The read and write ports never address the same byte in one cycle.
    a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write collide on one buffer byte");

    // Nothing leaves the block while the buffer is being cleared.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!m_valid_reg && !wb_valid_reg && !s_axis_tready))
        else $error("activity during the clearing sweep");

    // The end-of-readout mark sits on the final slot only.
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_last_reg == (m_slot_reg == lsbp_pkg::LAST_SLOT)))
        else $error("tlast does not match the final slot");

    // A new transaction is taken only once the previous readout has drained.
    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_valid_reg && !wb_valid_reg))
        else $error("transaction taken while work is outstanding");

endmodule
